/* src/effect_fade_envelope_unit_assert.svh */
// Assertion macros for the fade envelope unit.
// Included by the top level; needs no package and defines only macros.
`ifndef EFFECT_FADE_ENVELOPE_UNIT_ASSERT_SVH
`define EFFECT_FADE_ENVELOPE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fade envelope assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fade envelope assertion failed");

`endif

/* src/efe_pkg.sv */
// Shared types and constants of the fade envelope unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package efe_pkg;

	// Field widths
	localparam int LEVEL_W   = 3;
	localparam int ELAPSED_W = 10;
	localparam int DUR_W     = 16;
	localparam int TIMER_W   = 17;
	localparam int ALPHA_W   = 9;
	localparam int FRAC_W    = 8;
	localparam int CNT_W     = 3;
	localparam int IDX_W     = 2;

	// Highest level a trigger may ask for
	localparam logic [LEVEL_W-1:0] NUM_EFFECTS = 3'd4;

	localparam logic [TIMER_W-1:0] TIMER_MAX  = 17'h1FFFF;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

	// Register reset values
	localparam logic [DUR_W-1:0] FADE_IN_RST  = 16'd300;
	localparam logic [DUR_W-1:0] HOLD_RST     = 16'd1500;
	localparam logic [DUR_W-1:0] FADE_OUT_RST = 16'd500;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_FADE_IN  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HOLD     = 2'd1;
	localparam logic [IDX_W-1:0] REG_FADE_OUT = 2'd2;

	// Item kinds
	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_TRIGGER = 1'b1;

	typedef enum logic [1:0] {
		PH_FADE_IN  = 2'd0,
		PH_HOLD     = 2'd1,
		PH_FADE_OUT = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_STEP,
		ST_PREP,
		ST_DIV,
		ST_EMIT
	} efe_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic sum;
		logic step;
		logic div_init;
		logic div_iter;
		logic out_load;
	} efe_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic div_last;
	} efe_sts_t;

endpackage

`default_nettype wire

/* src/efe_ctrl.sv */
// Controller state machine of the fade envelope unit.
// Sequences one item through the datapath; depends on efe_pkg.
`default_nettype none

module efe_ctrl import efe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire efe_sts_t sts,
	output efe_cmd_t      cmd
);

	efe_state_t state_q, state_d;
	logic       m_valid_q;
	logic       emit_go;

	// The result register is free when empty or being taken this cycle
	assign emit_go = (state_q == ST_EMIT) && (!m_valid_q || m_tready);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_go) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM:  state_d = ST_STEP;
			ST_STEP: state_d = ST_PREP;
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_go) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands and handshake outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ST_SUM:  cmd.sum      = 1'b1;
			ST_STEP: cmd.step     = 1'b1;
			ST_PREP: cmd.div_init = 1'b1;
			ST_DIV:  cmd.div_iter = 1'b1;
			ST_EMIT: cmd.out_load = emit_go;
			default: cmd = '0;
		endcase
	end

	assign m_tvalid = m_valid_q;

endmodule

`default_nettype wire

/* src/efe_dp.sv */
// Datapath of the fade envelope unit: registers, envelope state,
// timer update and a bit-serial alpha divider. Depends on efe_pkg.
`default_nettype none

module efe_dp import efe_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [DUR_W-1:0]     cfg_wdata,
	input  wire logic                 in_kind,
	input  wire logic [LEVEL_W-1:0]   in_level,
	input  wire logic [ELAPSED_W-1:0] in_elapsed,
	input  wire efe_cmd_t             cmd,
	output efe_sts_t                  sts,
	output logic [LEVEL_W-1:0]        out_level,
	output logic [1:0]                out_phase,
	output logic [ALPHA_W-1:0]        out_alpha,
	output logic                      out_accepted
);

	logic [DUR_W-1:0]     fade_in_q, hold_q, fade_out_q;
	logic                 kind_q;
	logic [LEVEL_W-1:0]   req_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [LEVEL_W-1:0]   level_q;
	phase_t               phase_q;
	logic [TIMER_W-1:0]   timer_q;
	logic                 acc_q;
	logic [DUR_W-1:0]     div_dur_q;
	logic [DUR_W-1:0]     rem_q;
	logic [FRAC_W-1:0]    quo_q;
	logic                 sat_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [TIMER_W:0]     sum_wide;
	logic [TIMER_W-1:0]   sum_sat;
	logic                 trig_ok;
	logic [DUR_W-1:0]     step_dur;
	logic                 step_reached;
	logic [TIMER_W-1:0]   step_rest;
	logic [TIMER_W-1:0]   rem2;
	logic                 rem_ge;
	logic [TIMER_W-1:0]   rem_diff;
	logic [ALPHA_W-1:0]   ramp;
	logic [ALPHA_W-1:0]   alpha_d;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_in_q  <= FADE_IN_RST;
			hold_q     <= HOLD_RST;
			fade_out_q <= FADE_OUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_FADE_IN) begin
				fade_in_q <= cfg_wdata;
			end
			if (cfg_index == REG_HOLD) begin
				hold_q <= cfg_wdata;
			end
			if (cfg_index == REG_FADE_OUT) begin
				fade_out_q <= cfg_wdata;
			end
		end
	end

	// Input capture on the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q    <= in_kind;
			req_q     <= in_level;
			elapsed_q <= in_elapsed;
		end
	end

	// Saturating timer add and the trigger priority check
	assign sum_wide = {1'b0, timer_q} + (TIMER_W + 1)'(elapsed_q);
	assign sum_sat  = sum_wide[TIMER_W] ? TIMER_MAX : sum_wide[TIMER_W-1:0];
	assign trig_ok  = (req_q <= NUM_EFFECTS) && ((level_q == '0) || (req_q > level_q));

	// Duration of the phase that is running
	always_comb begin
		unique case (phase_q)
			PH_FADE_IN: step_dur = fade_in_q;
			PH_HOLD:    step_dur = hold_q;
			default:    step_dur = fade_out_q;
		endcase
	end

	assign step_reached = timer_q >= TIMER_W'(step_dur);
	assign step_rest    = timer_q - TIMER_W'(step_dur);

	// Envelope state: trigger or timer add, then at most one phase change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			phase_q <= PH_FADE_IN;
			timer_q <= '0;
			acc_q   <= 1'b0;
		end else if (cmd.sum) begin
			acc_q <= 1'b0;
			if (kind_q == KIND_TRIGGER) begin
				if (trig_ok) begin
					level_q <= req_q;
					phase_q <= PH_FADE_IN;
					timer_q <= '0;
					acc_q   <= 1'b1;
				end
			end else if (level_q != '0) begin
				timer_q <= sum_sat;
			end
		end else if (cmd.step) begin
			if ((kind_q == KIND_TICK) && (level_q != '0) && step_reached) begin
				unique case (phase_q)
					PH_FADE_IN: begin
						timer_q <= step_rest;
						phase_q <= PH_HOLD;
					end
					PH_HOLD: begin
						timer_q <= step_rest;
						phase_q <= PH_FADE_OUT;
					end
					default: begin
						level_q <= '0;
						phase_q <= PH_FADE_IN;
						timer_q <= '0;
					end
				endcase
			end
		end
	end

	// Restoring divider step: one quotient bit per cycle
	assign rem2     = {rem_q, 1'b0};
	assign rem_ge   = rem2 >= TIMER_W'(div_dur_q);
	assign rem_diff = rem2 - TIMER_W'(div_dur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_iter) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			div_dur_q <= (phase_q == PH_FADE_IN) ? fade_in_q : fade_out_q;
			sat_q     <= timer_q >= TIMER_W'((phase_q == PH_FADE_IN) ? fade_in_q : fade_out_q);
			rem_q     <= timer_q[DUR_W-1:0];
			quo_q     <= '0;
		end else if (cmd.div_iter) begin
			if (rem_ge) begin
				rem_q <= rem_diff[DUR_W-1:0];
			end else begin
				rem_q <= rem2[DUR_W-1:0];
			end
			quo_q <= {quo_q[FRAC_W-2:0], rem_ge};
		end
	end

	assign sts.div_last = (cnt_q == CNT_W'(FRAC_W - 1));

	// Alpha from the phase and the ramp fraction
	assign ramp = sat_q ? ALPHA_FULL : ALPHA_W'(quo_q);

	always_comb begin
		if (level_q == '0) begin
			alpha_d = '0;
		end else begin
			unique case (phase_q)
				PH_FADE_IN: alpha_d = ramp;
				PH_HOLD:    alpha_d = ALPHA_FULL;
				default:    alpha_d = ALPHA_FULL - ramp;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_level    <= level_q;
			out_phase    <= phase_q;
			out_alpha    <= alpha_d;
			out_accepted <= acc_q;
		end
	end

endmodule

`default_nettype wire

/* src/effect_fade_envelope_unit.sv */
// Each accepted item passes through these steps until its result is in the
// output register: capture, timer add or trigger check, phase change, divider
// set-up, eight quotient bits for the alpha fraction (a restoring divider, one
// quotient bit per cycle), and the result load, which waits for a free result
// register. The next item is taken in the cycle after that load, while the result
// may still wait for the downstream side. Configuration must be written only while
// no item is in flight (not enforced by the block); a write to index 3 has no effect.
// Top level of the fade envelope unit; uses efe_pkg, efe_ctrl, efe_dp and the
// assertion macro header.
`default_nettype none
`include "effect_fade_envelope_unit_assert.svh"

module effect_fade_envelope_unit import efe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Input item stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [15:0]      s_tdata,   // requested_level[2:0], elapsed_ms[12:3], zero pad
	input  wire logic             s_tuser,   // kind: 0 tick, 1 trigger
	// Result stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [15:0]           m_tdata,   // active_level[2:0], phase[4:3],
	                                         // alpha_q8[13:5], accepted[14], zero pad
	// Configuration write port
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [DUR_W-1:0] cfg_wdata
);

	efe_cmd_t           cmd;
	efe_sts_t           sts;
	logic [LEVEL_W-1:0] out_level;
	logic [1:0]         out_phase;
	logic [ALPHA_W-1:0] out_alpha;
	logic               out_accepted;

	// Sequencing
	efe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Envelope state and arithmetic
	efe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_kind      (s_tuser),
		.in_level     (s_tdata[2:0]),
		.in_elapsed   (s_tdata[12:3]),
		.cmd          (cmd),
		.sts          (sts),
		.out_level    (out_level),
		.out_phase    (out_phase),
		.out_alpha    (out_alpha),
		.out_accepted (out_accepted)
	);

	// Result packing
	assign m_tdata = {1'b0, out_accepted, out_alpha, out_phase, out_level};

	// One item at a time: no input is taken in the cycle after an acceptance
	`EFE_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// Alpha never exceeds full strength
	`EFE_ASSERT_NOW(a_alpha_range, clk, arst_n, m_tvalid, m_tdata[13:5] <= ALPHA_FULL)
	// An idle result reads fade-in with zero alpha
	`EFE_ASSERT_NOW(a_idle_zero, clk, arst_n, m_tvalid && (m_tdata[2:0] == 3'd0),
		(m_tdata[13:5] == 9'd0) && (m_tdata[4:3] == PH_FADE_IN))

endmodule

`default_nettype wire
